### design/raid5_block_read_recover_unit_macros.svh
// Assertion macros for the RAID5 block read recover unit
`ifndef RAID5_BLOCK_READ_RECOVER_UNIT_MACROS_SVH
`define RAID5_BLOCK_READ_RECOVER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define R5RR_ASSERT_IMP(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("r5rr assertion failed");

// next-cycle implication
`define R5RR_ASSERT_NXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("r5rr assertion failed");

`else

`define R5RR_ASSERT_IMP(name, ck, rs, ante, cons)
`define R5RR_ASSERT_NXT(name, ck, rs, ante, cons)

`endif

`endif

### design/r5rr_pkg.sv
// Shared types and constants for the RAID5 block read recover unit
package r5rr_pkg;

  localparam int DISKS_W    = 5;
  localparam int BLK_W      = 11;
  localparam int MASK_W     = 16;
  localparam int MASK_IDX_W = $clog2(MASK_W);
  localparam int WORD_W     = 32;
  localparam int NUM_W      = 32;
  localparam int IDX_W      = 4;
  localparam int OFS_W      = 10;
  localparam int DIV_W      = DISKS_W + BLK_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int DEF_MAX_DISKS       = 16;
  localparam int DEF_MAX_DISK_BLOCKS = 1024;

  localparam logic [DISKS_W-1:0] RST_DISK_COUNT    = 5'd2;
  localparam logic [BLK_W-1:0]   RST_STRIPE_BLOCKS = 11'd1;
  localparam logic [BLK_W-1:0]   RST_DISK_BLOCKS   = 11'd0;
  localparam logic [MASK_W-1:0]  RST_PRESENT_MASK  = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DISK_COUNT    = 2'd0,
    CFG_STRIPE_BLOCKS = 2'd1,
    CFG_DISK_BLOCKS   = 2'd2,
    CFG_PRESENT_MASK  = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic {
    STAT_OK      = 1'b0,
    STAT_UNAVAIL = 1'b1
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV_ROW,
    ST_DIV_LANE,
    ST_DIV_PHASE,
    ST_CHECK,
    ST_READ,
    ST_READ_WAIT,
    ST_SWEEP,
    ST_DRAIN,
    ST_FIN
  } seq_state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

endpackage

### design/r5rr_if.sv
// Request and result channel interfaces
interface r5rr_req_if import r5rr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [IDX_W-1:0]  disk_index;
  logic [OFS_W-1:0]  disk_offset;
  logic [WORD_W-1:0] load_word;
  logic [NUM_W-1:0]  block_number;

  modport source (
    output valid, operation, disk_index, disk_offset, load_word, block_number,
    input  ready
  );
  modport sink (
    input  valid, operation, disk_index, disk_offset, load_word, block_number,
    output ready
  );
endinterface

interface r5rr_rsp_if import r5rr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] read_word;
  logic              status;

  modport source (
    output valid, read_word, status,
    input  ready
  );
  modport sink (
    input  valid, read_word, status,
    output ready
  );
endinterface

### design/r5rr_div.sv
// Restoring divider, one quotient bit per cycle
module r5rr_div import r5rr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] count;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] divisor;
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   trial;

  always_comb begin
    shifted = {rem, quo[DIV_W-1]};
    trial   = shifted - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy  <= 1'b1;
        count <= CNT_W'(DIV_W);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      if (!trial[DIV_W]) begin
        rem <= trial[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

### design/r5rr_store.sv
// Single-port disk word store with registered read data
module r5rr_store import r5rr_pkg::*; #(
  parameter int ADDR_W = 14
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WORD_W-1:0] wdata,
  output logic [WORD_W-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### design/raid5_block_read_recover_unit.sv
// RAID5 left-symmetric read path: sequencer, shared divider and disk store
//
//   channel   dir  handshake        payload
//   request   in   valid/ready      operation, disk_index, disk_offset,
//                                   load_word, block_number
//   result    out  valid/ready      read_word, status
//   cfg       in   cfg_we           cfg_index, cfg_data
//
// A load request is written to the store straight from the idle state. A read
// request runs three 16-bit divisions on the shared divider, then reads the
// target disk when it is present, or sweeps every other disk through the
// single store port and rebuilds the block by XOR. Reads that fail the
// geometry or capacity check go straight to the result.
// Reset is synchronous; the store holds no reset. The result register frees
// the sequencer while a result waits for the sink.
module raid5_block_read_recover_unit import r5rr_pkg::*; #(
  parameter int MAX_DISKS       = DEF_MAX_DISKS,
  parameter int MAX_DISK_BLOCKS = DEF_MAX_DISK_BLOCKS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  r5rr_req_if.sink              request,
  r5rr_rsp_if.source            result
);

  `include "raid5_block_read_recover_unit_macros.svh"

  localparam int DI_W   = (MAX_DISKS > 1) ? $clog2(MAX_DISKS) : 1;
  localparam int OF_W   = (MAX_DISK_BLOCKS > 1) ? $clog2(MAX_DISK_BLOCKS) : 1;
  localparam int ADDR_W = DI_W + OF_W;
  localparam int SUM_W  = DISKS_W + 1;
  localparam int PROD_W = 2 * BLK_W;
  localparam int OFF_W  = PROD_W + 1;
  localparam logic [OFF_W-1:0] OFF_LIMIT = OFF_W'(MAX_DISK_BLOCKS);

  logic [DISKS_W-1:0] disk_count;
  logic [BLK_W-1:0]   stripe_blocks;
  logic [BLK_W-1:0]   disk_blocks;
  logic [MASK_W-1:0]  present_mask;

  seq_state_t state;
  seq_state_t state_next;

  logic [DIV_W-1:0]   num;
  logic               num_hi_zero;
  logic               miss_one;
  logic [BLK_W-1:0]   row;
  logic [DISKS_W-1:0] lane;
  logic [BLK_W-1:0]   sub_off;
  logic [DISKS_W-1:0] target;
  logic [OFF_W-1:0]   off;
  logic [DISKS_W-1:0] sweep_d;
  logic               pend;
  logic [WORD_W-1:0]  acc;
  logic               res_status;

  logic               out_valid;
  logic [WORD_W-1:0]  out_word;
  logic               out_status;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic              st_we;
  logic              st_re;
  logic [ADDR_W-1:0] st_addr;
  logic [WORD_W-1:0] st_rdata;

  logic               accept;
  logic               load_in_range;
  logic               geom_ok;
  logic [DISKS_W-1:0] n_less;
  logic [DIV_W-1:0]   cap;
  logic [DIV_W-1:0]   rowlen;
  logic               num_ok;
  logic [MASK_W-1:0]  miss_vec;
  logic [DISKS_W-1:0] extra;
  logic               miss_one_c;
  logic [DISKS_W-1:0] phase_rem;
  logic [DISKS_W-1:0] parity;
  logic [SUM_W-1:0]   sum;
  logic [DISKS_W-1:0] target_c;
  logic [PROD_W-1:0]  prod;
  logic [OFF_W-1:0]   off_c;
  logic               off_ok;
  logic               tgt_present;
  logic               out_free;
  logic               load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      disk_count    <= RST_DISK_COUNT;
      stripe_blocks <= RST_STRIPE_BLOCKS;
      disk_blocks   <= RST_DISK_BLOCKS;
      present_mask  <= RST_PRESENT_MASK;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DISK_COUNT:    disk_count    <= cfg_data[DISKS_W-1:0];
        CFG_STRIPE_BLOCKS: stripe_blocks <= cfg_data[BLK_W-1:0];
        CFG_DISK_BLOCKS:   disk_blocks   <= cfg_data[BLK_W-1:0];
        CFG_PRESENT_MASK:  present_mask  <= cfg_data[MASK_W-1:0];
      endcase
    end
  end

  // request decode and geometry
  always_comb begin
    accept        = request.valid && request.ready;
    load_in_range = (32'(request.disk_index) < MAX_DISKS) &&
                    (32'(request.disk_offset) < MAX_DISK_BLOCKS);
    geom_ok = (disk_count >= DISKS_W'(2)) && (32'(disk_count) <= MAX_DISKS) &&
              (stripe_blocks != '0);
    n_less  = disk_count - DISKS_W'(1);
    cap     = DIV_W'(disk_blocks) * DIV_W'(n_less);
    rowlen  = DIV_W'(stripe_blocks) * DIV_W'(n_less);
    num_ok  = num_hi_zero && (num < cap);
    for (int d = 0; d < MASK_W; d++) begin
      miss_vec[d] = (DISKS_W'(d) < disk_count) && !present_mask[d];
    end
    extra = (disk_count > DISKS_W'(MASK_W)) ? disk_count - DISKS_W'(MASK_W) : '0;
    miss_one_c = ((extra == '0) && (miss_vec != '0) &&
                  ((miss_vec & (miss_vec - MASK_W'(1))) == '0)) ||
                 ((extra == DISKS_W'(1)) && (miss_vec == '0));
    phase_rem = div_rsp.remainder[DISKS_W-1:0];
    parity    = n_less - phase_rem;
    sum       = {1'b0, parity} + {1'b0, lane} + SUM_W'(1);
    target_c  = (sum >= {1'b0, disk_count}) ? DISKS_W'(sum - {1'b0, disk_count}) :
                sum[DISKS_W-1:0];
    prod      = PROD_W'(stripe_blocks) * PROD_W'(row);
    off_c     = {1'b0, prod} + OFF_W'(sub_off);
    off_ok    = (off < OFF_W'(disk_blocks)) && (off < OFF_LIMIT);
    tgt_present = (target < DISKS_W'(MASK_W)) && present_mask[target[MASK_IDX_W-1:0]];
    out_free  = !out_valid || result.ready;
    load_out  = (state == ST_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    request.ready    = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = num;
    div_req.divisor  = rowlen;
    st_we            = 1'b0;
    st_re            = 1'b0;
    st_addr          = {DI_W'(request.disk_index), OF_W'(request.disk_offset)};
    unique case (state)
      ST_IDLE: begin
        request.ready = 1'b1;
        st_we = request.valid && (request.operation == OP_LOAD) && load_in_range;
        if (request.valid && (request.operation == OP_READ)) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        if (geom_ok && num_ok) begin
          div_req.start = 1'b1;
          state_next    = ST_DIV_ROW;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_DIV_ROW: begin
        div_req.dividend = div_rsp.remainder;
        div_req.divisor  = DIV_W'(stripe_blocks);
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          state_next    = ST_DIV_LANE;
        end
      end
      ST_DIV_LANE: begin
        div_req.dividend = DIV_W'(row);
        div_req.divisor  = DIV_W'(disk_count);
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          state_next    = ST_DIV_PHASE;
        end
      end
      ST_DIV_PHASE: begin
        if (div_rsp.done) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!off_ok) begin
          state_next = ST_FIN;
        end else if (tgt_present) begin
          state_next = ST_READ;
        end else if (miss_one) begin
          state_next = ST_SWEEP;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_READ: begin
        st_re      = 1'b1;
        st_addr    = {DI_W'(target), OF_W'(off)};
        state_next = ST_READ_WAIT;
      end
      ST_READ_WAIT: begin
        state_next = ST_FIN;
      end
      ST_SWEEP: begin
        st_re   = (sweep_d != target);
        st_addr = {DI_W'(sweep_d), OF_W'(off)};
        if (sweep_d == n_less) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        num         <= request.block_number[DIV_W-1:0];
        num_hi_zero <= (request.block_number[NUM_W-1:DIV_W] == '0);
        res_status  <= STAT_UNAVAIL;
      end
      ST_PREP: begin
        miss_one <= miss_one_c;
      end
      ST_DIV_ROW: begin
        if (div_rsp.done) begin
          row <= div_rsp.quotient[BLK_W-1:0];
        end
      end
      ST_DIV_LANE: begin
        if (div_rsp.done) begin
          lane    <= div_rsp.quotient[DISKS_W-1:0];
          sub_off <= div_rsp.remainder[BLK_W-1:0];
        end
      end
      ST_DIV_PHASE: begin
        if (div_rsp.done) begin
          target <= target_c;
          off    <= off_c;
        end
      end
      ST_CHECK: begin
        sweep_d <= '0;
        pend    <= 1'b0;
        acc     <= '0;
      end
      ST_READ_WAIT: begin
        acc        <= st_rdata;
        res_status <= STAT_OK;
      end
      ST_SWEEP: begin
        sweep_d <= sweep_d + DISKS_W'(1);
        pend    <= st_re;
        if (pend) begin
          acc <= acc ^ st_rdata;
        end
      end
      ST_DRAIN: begin
        if (pend) begin
          acc <= acc ^ st_rdata;
        end
        res_status <= STAT_OK;
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_word   <= (res_status == STAT_OK) ? acc : '0;
      out_status <= res_status;
    end
  end

  assign result.valid     = out_valid;
  assign result.read_word = out_word;
  assign result.status    = out_status;

  r5rr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  r5rr_store #(
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .re    (st_re),
    .addr  (st_addr),
    .wdata (request.load_word),
    .rdata (st_rdata)
  );

  `R5RR_ASSERT_IMP(a_unavail_zero, clk, rst, result.valid && (result.status == STAT_UNAVAIL), result.read_word == '0)
  `R5RR_ASSERT_IMP(a_div_start_idle, clk, rst, div_req.start, !div_rsp.busy)
  `R5RR_ASSERT_NXT(a_read_blocks, clk, rst, accept && (request.operation == OP_READ), !request.ready)
  `R5RR_ASSERT_IMP(a_sweep_skip, clk, rst, st_re && (state == ST_SWEEP), sweep_d != target)

endmodule
